FILE: rtl/core/msw_pkg.sv
// Package: shared constants and widths for the maximum-sum sliding window core
`timescale 1ns / 1ps

package msw_pkg;

    localparam int MAX_WINDOW  = 256;
    localparam int MAX_LENGTH  = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int CFG_BITS  = 9;
    localparam int IDX_BITS  = 12;
    localparam int SUM_BITS  = 24;
    localparam int ADDR_BITS = $clog2(MAX_WINDOW);
    localparam int K_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int CNT_BITS  = $clog2(MAX_LENGTH + 1);

    localparam logic [K_BITS-1:0] K_RESET = K_BITS'(3);

    typedef struct packed {
        logic                          last;
        logic                          active;
        logic                          leave_valid;
        logic                          window_full;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [IDX_BITS-1:0]           start;
    } msw_stage_t;

endpackage

FILE: rtl/core/msw_sample_if.sv
// Interface: sample request channel (valid, ready, sample, last)
`timescale 1ns / 1ps

interface msw_sample_if
    import msw_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: rtl/core/msw_result_if.sv
// Interface: result request channel (valid, ready, found, indexes, sum)
`timescale 1ns / 1ps

interface msw_result_if
    import msw_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [IDX_BITS-1:0]        start_index;
    logic [IDX_BITS-1:0]        end_index;
    logic signed [SUM_BITS-1:0] best_sum;

    modport source (output valid, output found, output start_index, output end_index,
                    output best_sum, input ready);
    modport sink   (input valid, input found, input start_index, input end_index,
                    input best_sum, output ready);
endinterface

FILE: rtl/core/msw_ram.sv
// Simple dual-port RAM with registered read, read-before-write on a shared address
`timescale 1ns / 1ps

module msw_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/max_sum_fixed_window_core.sv
// Top level: maximum-sum fixed-length sliding window over a sample stream
//
//   channel   | dir | handshake      | payload
//   ----------+-----+----------------+---------------------------------------------
//   samples   | in  | valid / ready  | sample (s16), last
//   results   | out | valid / ready  | found, start_index, end_index, best_sum (s24)
//   cfg       | in  | cfg_wen        | cfg_wdata (window length, 9 bits)
//
// One sample per cycle while not stalled. A request is accepted into an input stage that
// reads the leaving sample from the delay-line RAM; the update stage then updates the
// running sum and best window, and loads the result register for a last sample.
// Reset restores window length 3 and an empty sequence. Samples stall only while a
// last sample waits in the update stage behind an unconsumed result.
`timescale 1ns / 1ps

module max_sum_fixed_window_core
    import msw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    msw_sample_if.sink          samples,
    msw_result_if.source        results,
    input  logic                cfg_wen,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    logic [K_BITS-1:0]          k_reg, k_next;
    logic [ADDR_BITS-1:0]       wp_reg, wp_next;
    logic [CNT_BITS-1:0]        count_reg, count_next;

    logic                       s1_valid_reg, s1_valid_next;
    msw_stage_t                 s1_reg, s1_next;

    logic signed [SUM_BITS-1:0] sum_reg, sum_next;
    logic signed [SUM_BITS-1:0] best_reg, best_next;
    logic [IDX_BITS-1:0]        best_start_reg, best_start_next;
    logic                       have_reg, have_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       found_reg, found_next;
    logic [IDX_BITS-1:0]        start_reg, start_next;
    logic [IDX_BITS-1:0]        end_reg, end_next;
    logic signed [SUM_BITS-1:0] out_sum_reg, out_sum_next;

    logic                       stall;
    logic                       accept;
    logic                       active;
    logic [CNT_BITS-1:0]        k_wide;
    logic [SAMPLE_BITS-1:0]     leave_raw;
    logic signed [SUM_BITS-1:0] x_ext, leave_ext, sum_upd;
    logic                       take;

    assign stall  = s1_valid_reg && s1_reg.last && out_valid_reg && !results.ready;
    assign accept = samples.valid && !stall;
    assign samples.ready = !stall;

    assign k_wide = CNT_BITS'(k_reg);
    assign active = count_reg < CNT_BITS'(MAX_LENGTH);

    // delay line
    msw_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_ram (
        .clk   (clk),
        .wen   (accept && active),
        .waddr (wp_reg),
        .wdata (samples.sample),
        .ren   (accept),
        .raddr (wp_reg - k_reg[ADDR_BITS-1:0]),
        .rdata (leave_raw)
    );

    // input stage
    always_comb
    begin
        k_next        = k_reg;
        wp_next       = wp_reg;
        count_next    = count_reg;
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;

        if (!stall)
        begin
            s1_valid_next = accept;
        end

        if (accept)
        begin
            s1_next.last        = samples.last;
            s1_next.active      = active;
            s1_next.leave_valid = count_reg >= k_wide;
            s1_next.window_full = count_reg >= (k_wide - CNT_BITS'(1));
            s1_next.sample      = samples.sample;
            s1_next.start       = IDX_BITS'(count_reg + CNT_BITS'(1) - k_wide);
            if (samples.last)
            begin
                wp_next    = '0;
                count_next = '0;
            end
            else if (active)
            begin
                wp_next    = wp_reg + ADDR_BITS'(1);
                count_next = count_reg + CNT_BITS'(1);
            end
        end

        if (cfg_wen)
        begin
            if (cfg_wdata == '0)
            begin
                k_next = K_BITS'(1);
            end
            else if (32'(cfg_wdata) > MAX_WINDOW)
            begin
                k_next = K_BITS'(MAX_WINDOW);
            end
            else
            begin
                k_next = K_BITS'(cfg_wdata);
            end
            wp_next    = '0;
            count_next = '0;
        end
    end

    // update stage and result register
    always_comb
    begin
        x_ext     = SUM_BITS'(s1_reg.sample);
        leave_ext = s1_reg.leave_valid ? SUM_BITS'($signed(leave_raw)) : '0;
        sum_upd   = s1_reg.active ? (sum_reg + x_ext - leave_ext) : sum_reg;
        take      = s1_reg.active && s1_reg.window_full && (!have_reg || sum_upd > best_reg);

        sum_next        = sum_reg;
        best_next       = best_reg;
        best_start_next = best_start_reg;
        have_next       = have_reg;

        out_valid_next = out_valid_reg && !results.ready;
        found_next     = found_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        out_sum_next   = out_sum_reg;

        if (s1_valid_reg && !stall)
        begin
            sum_next = sum_upd;
            if (take)
            begin
                best_next       = sum_upd;
                best_start_next = s1_reg.start;
                have_next       = 1'b1;
            end
            if (s1_reg.last)
            begin
                out_valid_next = 1'b1;
                found_next     = have_next;
                start_next     = have_next ? best_start_next : '0;
                end_next       = have_next ?
                                 (best_start_next + IDX_BITS'(k_reg) - IDX_BITS'(1)) : '0;
                out_sum_next   = have_next ? best_next : '0;
                sum_next        = '0;
                best_next       = '0;
                best_start_next = '0;
                have_next       = 1'b0;
            end
        end

        if (cfg_wen)
        begin
            sum_next        = '0;
            best_next       = '0;
            best_start_next = '0;
            have_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg          <= K_RESET;
            wp_reg         <= '0;
            count_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            sum_reg        <= '0;
            best_reg       <= '0;
            best_start_reg <= '0;
            have_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            k_reg          <= k_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            s1_valid_reg   <= s1_valid_next;
            sum_reg        <= sum_next;
            best_reg       <= best_next;
            best_start_reg <= best_start_next;
            have_reg       <= have_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        found_reg   <= found_next;
        start_reg   <= start_next;
        end_reg     <= end_next;
        out_sum_reg <= out_sum_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.found       = found_reg;
    assign results.start_index = start_reg;
    assign results.end_index   = end_reg;
    assign results.best_sum    = out_sum_reg;

endmodule

FILE: rtl/core/msw_checker.sv
// Checker: port-level assertions for the sliding window core, with its bind
`timescale 1ns / 1ps

module msw_checker
    import msw_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       found,
    input logic [IDX_BITS-1:0]        start_index,
    input logic [IDX_BITS-1:0]        end_index,
    input logic signed [SUM_BITS-1:0] best_sum
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(start_index)
            && $stable(end_index) && $stable(best_sum))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> start_index == '0 && end_index == '0 && best_sum == '0)
        else $error("empty result carries nonzero fields");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> end_index >= start_index)
        else $error("window ends before it starts");

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (end_index - start_index) < IDX_BITS'(MAX_WINDOW))
        else $error("window span exceeds maximum length");

endmodule

bind max_sum_fixed_window_core msw_checker u_msw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .found       (results.found),
    .start_index (results.start_index),
    .end_index   (results.end_index),
    .best_sum    (results.best_sum)
);

FILE: tb/tb_max_sum_fixed_window_core.sv
// Testbench: randomized and directed checks of the maximum-sum sliding window core
`timescale 1ns / 1ps

module tb_max_sum_fixed_window_core;
    import msw_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic                       found;
        logic [IDX_BITS-1:0]        start_index;
        logic [IDX_BITS-1:0]        end_index;
        logic signed [SUM_BITS-1:0] best_sum;
    } window_result_t;

    class best_window_tracker;
        logic signed [SAMPLE_BITS-1:0] history [MAX_WINDOW];
        logic [ADDR_BITS-1:0]          wr_ptr;
        longint                        run_sum;
        int unsigned                   seen;
        longint                        top_sum;
        int unsigned                   top_start;
        bit                            top_valid;
        logic [CFG_BITS-1:0]           wlen;
        window_result_t                pending_best [$];
        int                            mismatches;

        function new();
            foreach (history[i]) history[i] = '0;
            wlen = CFG_BITS'(3);
            mismatches = 0;
            restart_sequence();
        endfunction

        function void restart_sequence();
            wr_ptr = '0;
            run_sum = 0;
            seen = 0;
            top_sum = 0;
            top_start = 0;
            top_valid = 0;
        endfunction

        function void set_length(logic [CFG_BITS-1:0] v);
            wlen = v;
            restart_sequence();
        endfunction

        function int unsigned span();
            if (wlen == 0) return 1;
            if (wlen > MAX_WINDOW) return MAX_WINDOW;
            return wlen;
        endfunction

        function void take_sample(logic signed [SAMPLE_BITS-1:0] s, bit is_last);
            int unsigned    k;
            int unsigned    old_pos;
            longint         leaving;
            longint         clipped;
            window_result_t r;
            k = span();
            if (seen < MAX_LENGTH) begin
                old_pos = (int'(wr_ptr) + MAX_WINDOW - k) % MAX_WINDOW;
                leaving = (seen >= k) ? longint'(history[old_pos]) : 0;
                run_sum = run_sum + longint'(s) - leaving;
                history[wr_ptr] = s;
                wr_ptr = wr_ptr + 1'b1;
                if (seen + 1 >= k && (!top_valid || run_sum > top_sum)) begin
                    top_sum = run_sum;
                    top_start = seen + 1 - k;
                    top_valid = 1;
                end
                seen++;
            end
            if (!is_last) return;
            r.found = top_valid;
            r.start_index = '0;
            r.end_index = '0;
            r.best_sum = '0;
            if (top_valid) begin
                clipped = top_sum;
                if (clipped > 64'sd8388607) clipped = 64'sd8388607;
                if (clipped < -64'sd8388608) clipped = -64'sd8388608;
                r.start_index = IDX_BITS'(top_start);
                r.end_index = IDX_BITS'(top_start + k - 1);
                r.best_sum = SUM_BITS'(clipped);
            end
            pending_best.push_back(r);
            restart_sequence();
        endfunction

        function void compare_result(window_result_t got);
            window_result_t want;
            if (pending_best.size() == 0) begin
                $display("%0t: unexpected result found=%0d start=%0d end=%0d sum=%0d",
                         $time, got.found, got.start_index, got.end_index, got.best_sum);
                mismatches++;
                return;
            end
            want = pending_best.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                mismatches++;
            end
            if (got.start_index !== want.start_index) begin
                $display("%0t: start_index expected %0d actual %0d",
                         $time, want.start_index, got.start_index);
                mismatches++;
            end
            if (got.end_index !== want.end_index) begin
                $display("%0t: end_index expected %0d actual %0d",
                         $time, want.end_index, got.end_index);
                mismatches++;
            end
            if (got.best_sum !== want.best_sum) begin
                $display("%0t: best_sum expected %0d actual %0d",
                         $time, want.best_sum, got.best_sum);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wen;
    logic [CFG_BITS-1:0] cfg_wdata;
    bit                  send_gaps;
    bit                  take_gaps;
    bit                  hold_request;
    int unsigned         cycles = 0;
    best_window_tracker  tracker;

    msw_sample_if sample_ch ();
    msw_result_if result_ch ();

    max_sum_fixed_window_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit is_last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample <= s;
        sample_ch.last <= is_last;
        do @(posedge clk); while (!sample_ch.ready);
        tracker.take_sample(s, is_last);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return SAMPLE_BITS'($urandom_range(0, 8) - 4);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sequence(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            send_sample(pick_sample(), i == n - 1);
    endtask

    task automatic write_length(input logic [CFG_BITS-1:0] v);
        sample_ch.valid <= 1'b0;
        while (tracker.pending_best.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen <= 1'b0;
        tracker.set_length(v);
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] v, input int unsigned budget);
        int unsigned k;
        int unsigned n;
        int unsigned used;
        write_length(v);
        send_gaps = $urandom_range(0, 3) != 0;
        take_gaps = $urandom_range(0, 3) != 0;
        k = tracker.span();
        used = 0;
        while (used < budget)
        begin
            if ($urandom_range(0, 9) < 2)
                n = $urandom_range(1, k);
            else if (k >= 200)
                n = $urandom_range(k, k + 40);
            else
                n = $urandom_range(k, 4 * k + 8);
            send_sequence(n);
            used += n;
        end
    endtask

    initial
    begin
        window_result_t got;
        int             pause;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            pause = take_gaps ? $urandom_range(0, 8) : 0;
            if (pause > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            got.found = result_ch.found;
            got.start_index = result_ch.start_index;
            got.end_index = result_ch.end_index;
            got.best_sum = result_ch.best_sum;
            tracker.compare_result(got);
        end
    end

    initial
    begin
        logic [CFG_BITS-1:0] lens [];
        lens = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd9, 9'd13, 9'd31, 9'd256, 9'd511};
        tracker = new();
        send_gaps = 1;
        take_gaps = 1;
        hold_request = 0;
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_wdata <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.sample <= '0;
        sample_ch.last <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: window length from reset, short sequences, ties, extremes
        send_sample(16'sh7fff, 0);
        send_sample(-16'sd1, 1);
        send_sample(16'sh7fff, 0);
        send_sample(16'sh7fff, 0);
        send_sample(16'sh7fff, 0);
        send_sample(16'sd0, 0);
        send_sample(16'sh8000, 1);
        repeat (4) send_sample(16'sh8000, 0);
        send_sample(16'sh8000, 1);
        send_sample(16'sd5, 1);

        // directed: length written mid-sequence drops the open sequence
        send_sample(16'sd3, 0);
        send_sample(16'sd4, 0);
        write_length(9'd1);
        send_sample(16'sd7, 0);
        send_sample(-16'sd7, 0);
        send_sample(16'sd7, 1);
        write_length(9'd0);
        send_sample(-16'sd3, 0);
        send_sample(16'sd9, 1);

        foreach (lens[i])
            run_phase(lens[i], (lens[i] >= 200) ? 1 : 40);
        run_phase(CFG_BITS'($urandom_range(1, 20)), 40);

        // drive the block into a stall behind a held-off receiver
        write_length(9'd1);
        send_gaps = 0;
        take_gaps = 0;
        hold_request = 1;
        repeat (30) send_sequence($urandom_range(1, 3));
        send_gaps = 1;
        take_gaps = 1;

        run_phase(CFG_BITS'($urandom_range(1, 12)), 40);

        sample_ch.valid <= 1'b0;
        while (tracker.pending_best.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_best.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
